>>> rtl/core/smcd_pkg.sv
package smcd_pkg;

    // Register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SPC_W      = 16;
    localparam int CCNT_W     = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_COLUMN = 2'd0,
        CFG_COLUMN_COUNT       = 2'd1,
        CFG_SCROLL_MODE        = 2'd2
    } t_cfg_idx;

    localparam logic [SPC_W-1:0]  SPC_RESET  = 16'd1;
    localparam logic [CCNT_W-1:0] CCNT_RESET = 13'd2;
    localparam logic [CCNT_W-1:0] CCNT_MIN   = 13'd2;

    // Configuration seen by the column tracker
    typedef struct packed {
        logic [SPC_W-1:0]  samples_per_column;
        logic [CCNT_W-1:0] column_count;
        logic              scroll_mode;
    } t_cfg;

endpackage

>>> rtl/core/stereo_minmax_column_decimator.sv
// Channel   Dir  Handshake                          Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata: left, right
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: six extremes, position; tuser: shift
// cfg       in   i_cfg_we                           i_cfg_idx, i_cfg_data
//
// One item per cycle is accepted unless a closing item waits on a stalled result; a column
// result passes the input register, then the result register.
// Synchronous active-low reset restores extremes, counter, position, config and valid flags.
// A stalled result only stops an item that would close the next column; items that
// just fold into the extremes keep flowing.
module stereo_minmax_column_decimator #(
    parameter int MAX_COLUMNS = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [smcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [smcd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // left_sample, right_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // min_mid, max_mid, min_left, max_left, min_right, max_right, column_position
    output logic [((6*SAMPLE_BITS+$clog2(MAX_COLUMNS)+7)/8)*8-1:0] o_m_axis_tdata,
    // shift_first
    output logic                              o_m_axis_tuser
);

    localparam int SB  = SAMPLE_BITS;
    localparam int PW  = $clog2(MAX_COLUMNS);
    localparam int ODW = ((6*SB+PW+7)/8)*8;

    smcd_pkg::t_cfg r_cfg;

    logic                 r_s1_vld;
    logic signed [SB-1:0] r_s1_l;
    logic signed [SB-1:0] r_s1_r;
    logic signed [SB:0]   w_sum;
    logic signed [SB-1:0] w_mid;

    logic                 w_emit;
    logic                 w_out_free;
    logic                 w_s1_adv;
    logic [PW-1:0]        w_pos;
    logic                 w_shift;

    logic signed [SB-1:0] w_min_m, w_max_m, w_min_l, w_max_l, w_min_r, w_max_r;

    logic                 r_out_vld;
    logic signed [SB-1:0] r_min_m, r_max_m, r_min_l, r_max_l, r_min_r, r_max_r;
    logic [PW-1:0]        r_pos;
    logic                 r_shift;

    // Write configuration registers, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.samples_per_column <= smcd_pkg::SPC_RESET;
            r_cfg.column_count       <= smcd_pkg::CCNT_RESET;
            r_cfg.scroll_mode        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                smcd_pkg::CFG_SAMPLES_PER_COLUMN:
                    r_cfg.samples_per_column <= i_cfg_data[smcd_pkg::SPC_W-1:0];
                smcd_pkg::CFG_COLUMN_COUNT:
                    r_cfg.column_count <= i_cfg_data[smcd_pkg::CCNT_W-1:0];
                smcd_pkg::CFG_SCROLL_MODE:
                    r_cfg.scroll_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stall control
    assign w_out_free      = !r_out_vld || i_m_axis_tready;
    assign w_s1_adv        = r_s1_vld && (!w_emit || w_out_free);
    assign o_s_axis_tready = !r_s1_vld || w_s1_adv;

    // Capture the input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_s1_l <= i_s_axis_tdata[SB-1:0];
            r_s1_r <= i_s_axis_tdata[2*SB-1:SB];
        end
    end

    // Mid value, floor of the halved sum
    assign w_sum = {r_s1_l[SB-1], r_s1_l} + {r_s1_r[SB-1], r_s1_r};
    assign w_mid = w_sum[SB:1];

    smcd_extreme #(.SAMPLE_BITS(SB)) u_ext_mid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_upd(w_s1_adv), .i_close(w_emit),
        .i_smp(w_mid), .o_min(w_min_m), .o_max(w_max_m)
    );

    smcd_extreme #(.SAMPLE_BITS(SB)) u_ext_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_upd(w_s1_adv), .i_close(w_emit),
        .i_smp(r_s1_l), .o_min(w_min_l), .o_max(w_max_l)
    );

    smcd_extreme #(.SAMPLE_BITS(SB)) u_ext_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_upd(w_s1_adv), .i_close(w_emit),
        .i_smp(r_s1_r), .o_min(w_min_r), .o_max(w_max_r)
    );

    smcd_column #(.MAX_COLUMNS(MAX_COLUMNS)) u_column (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_adv(w_s1_adv),
        .o_emit(w_emit), .o_pos(w_pos), .o_shift(w_shift)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_adv && w_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_emit) begin
            r_min_m <= w_min_m;
            r_max_m <= w_max_m;
            r_min_l <= w_min_l;
            r_max_l <= w_max_l;
            r_min_r <= w_min_r;
            r_max_r <= w_max_r;
            r_pos   <= w_pos;
            r_shift <= w_shift;
        end
    end

    // Pack the result item
    always_comb begin
        o_m_axis_tdata                   = '0;
        o_m_axis_tdata[SB-1:0]           = r_min_m;
        o_m_axis_tdata[2*SB-1:SB]        = r_max_m;
        o_m_axis_tdata[3*SB-1:2*SB]      = r_min_l;
        o_m_axis_tdata[4*SB-1:3*SB]      = r_max_l;
        o_m_axis_tdata[5*SB-1:4*SB]      = r_min_r;
        o_m_axis_tdata[6*SB-1:5*SB]      = r_max_r;
        o_m_axis_tdata[6*SB+PW-1:6*SB]   = r_pos;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_shift;

    // A closing item never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_emit) |-> w_out_free)
        else $error("column result overwritten while stalled");

    // Input side blocks only while the input register holds an item
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_s1_vld)
        else $error("input stalled with empty input register");

    // Every emitted column covers at least one sample
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_min_l <= r_max_l) && (r_min_r <= r_max_r) && (r_min_m <= r_max_m)))
        else $error("column extremes out of order");

    // Scroll flag follows the mode of the item that closed the column
    a_shift_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_emit) |=> (r_shift == $past(r_cfg.scroll_mode)))
        else $error("shift flag does not match scroll mode");

endmodule

>>> rtl/core/smcd_extreme.sv
module smcd_extreme #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_upd,
    input  logic                          i_close,
    input  logic signed [SAMPLE_BITS-1:0] i_smp,
    output logic signed [SAMPLE_BITS-1:0] o_min,
    output logic signed [SAMPLE_BITS-1:0] o_max
);

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic signed [SAMPLE_BITS-1:0] n_min;
    logic signed [SAMPLE_BITS-1:0] n_max;

    // Fold the new sample into the running extremes
    always_comb begin
        n_min = (i_smp < r_min) ? i_smp : r_min;
        n_max = (i_smp > r_max) ? i_smp : r_max;
    end

    assign o_min = n_min;
    assign o_max = n_max;

    // Hold the extremes, restart them when a column closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= SMAX;
            r_max <= SMIN;
        end else if (i_upd) begin
            if (i_close) begin
                r_min <= SMAX;
                r_max <= SMIN;
            end else begin
                r_min <= n_min;
                r_max <= n_max;
            end
        end
    end

endmodule

>>> rtl/core/smcd_column.sv
module smcd_column #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smcd_pkg::t_cfg                 i_cfg,
    input  logic                           i_adv,
    output logic                           o_emit,
    output logic [$clog2(MAX_COLUMNS)-1:0] o_pos,
    output logic                           o_shift
);

    localparam int PW = $clog2(MAX_COLUMNS);
    localparam int CW = (PW + 1 > smcd_pkg::CCNT_W) ? PW + 1 : smcd_pkg::CCNT_W;
    localparam logic [CW-1:0] NMAX = CW'(MAX_COLUMNS);

    logic [smcd_pkg::SPC_W-1:0] r_cnt;
    logic [smcd_pkg::SPC_W-1:0] n_cnt;
    logic [smcd_pkg::SPC_W-1:0] w_spc;
    logic [PW-1:0]              r_wp;
    logic [PW-1:0]              n_wp;
    logic [CW-1:0]              w_cc;
    logic [CW-1:0]              w_n;
    logic [PW-1:0]              w_last;
    logic [PW-1:0]              w_wp_cl;
    logic [CW-1:0]              w_wp_inc;

    // Close the column once the count reaches samples per column
    always_comb begin
        n_cnt  = r_cnt + 1'b1;
        w_spc  = (i_cfg.samples_per_column == '0) ? smcd_pkg::SPC_W'(1)
                                                  : i_cfg.samples_per_column;
        o_emit = (n_cnt >= w_spc);
    end

    // Clamp the column count and the write position
    always_comb begin
        w_cc = CW'(i_cfg.column_count);
        if (i_cfg.column_count < smcd_pkg::CCNT_MIN) begin
            w_n = CW'(smcd_pkg::CCNT_MIN);
        end else if (w_cc > NMAX) begin
            w_n = NMAX;
        end else begin
            w_n = w_cc;
        end
        w_last   = PW'(w_n - 1'b1);
        w_wp_cl  = (r_wp > w_last) ? w_last : r_wp;
        w_wp_inc = CW'(w_wp_cl) + 1'b1;
        n_wp     = (w_wp_inc >= w_n) ? '0 : PW'(w_wp_inc);
        o_pos    = i_cfg.scroll_mode ? w_last : w_wp_cl;
        o_shift  = i_cfg.scroll_mode;
    end

    // Advance the counter per item, and the position per closed column outside scroll mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
        end else if (i_adv) begin
            r_cnt <= o_emit ? '0 : n_cnt;
            if (o_emit && !i_cfg.scroll_mode) begin
                r_wp <= n_wp;
            end
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int           CLK_HALF     = 5;
    localparam int           CYCLE_LIMIT  = 1_000_000;
    localparam int           PIPE_CYCLES  = 4;
    localparam int           RANDOM_PAIRS = 1600;
    localparam int           MAX_COLS     = 4096;
    localparam logic [smcd_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic signed [15:0] min_mid;
        logic signed [15:0] max_mid;
        logic signed [15:0] min_left;
        logic signed [15:0] max_left;
        logic signed [15:0] min_right;
        logic signed [15:0] max_right;
        logic [11:0]        position;
        logic               shift;
    } t_column;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [smcd_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [smcd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic [31:0]                     s_data = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [111:0]                    m_data;
    logic                            m_user;

    // Mirror of the block's registers and running state
    logic [15:0]        mdl_spc;
    logic [12:0]        mdl_ccnt;
    logic               mdl_scroll;
    logic signed [15:0] run_min_mid, run_max_mid;
    logic signed [15:0] run_min_left, run_max_left;
    logic signed [15:0] run_min_right, run_max_right;
    logic [15:0]        pairs_in_column;
    logic [11:0]        next_position;

    t_column pending_columns[$];
    int      errors = 0;
    int      pairs_sent = 0;
    int      columns_seen = 0;
    int      cycles = 0;
    bit      steady = 1'b0;

    stereo_minmax_column_decimator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("stereo_minmax_column_decimator verification failed");
            $finish;
        end
    end

    // Clear the extremes and the pair counter after a column closes
    function automatic void clear_extremes();
        run_min_mid     = 16'sh7FFF;
        run_max_mid     = -16'sh8000;
        run_min_left    = 16'sh7FFF;
        run_max_left    = -16'sh8000;
        run_min_right   = 16'sh7FFF;
        run_max_right   = -16'sh8000;
        pairs_in_column = '0;
    endfunction

    // Fold one stereo pair into the extremes; return 1 when it closes a column
    function automatic bit fold_pair(input logic signed [15:0] l, input logic signed [15:0] r,
                                     output t_column col);
        logic signed [16:0] sum;
        logic signed [15:0] mid;
        int                 spc;
        int                 n;
        sum = l + r;
        mid = sum[16:1];
        spc = (mdl_spc == 0) ? 1 : int'(mdl_spc);
        n   = int'(mdl_ccnt);
        if (n < 2) n = 2;
        if (n > MAX_COLS) n = MAX_COLS;

        if (mid < run_min_mid)  run_min_mid = mid;
        if (mid > run_max_mid)  run_max_mid = mid;
        if (l < run_min_left)   run_min_left = l;
        if (l > run_max_left)   run_max_left = l;
        if (r < run_min_right)  run_min_right = r;
        if (r > run_max_right)  run_max_right = r;
        pairs_in_column = pairs_in_column + 16'd1;
        col = '0;
        if (int'(pairs_in_column) < spc) return 1'b0;

        col.min_mid   = run_min_mid;
        col.max_mid   = run_max_mid;
        col.min_left  = run_min_left;
        col.max_left  = run_max_left;
        col.min_right = run_min_right;
        col.max_right = run_max_right;
        if (mdl_scroll) begin
            col.position = 12'(n - 1);
            col.shift    = 1'b1;
        end else begin
            // clamp a position left behind by a shrunk column count
            if (int'(next_position) > n - 1) next_position = 12'(n - 1);
            col.position  = next_position;
            col.shift     = 1'b0;
            next_position = (int'(next_position) + 1 >= n) ? 12'd0 : next_position + 12'd1;
        end
        clear_extremes();
        return 1'b1;
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Result side: hold ready for random stretches
    int ready_hold = 0;
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            int roll;
            roll = $urandom_range(99);
            if (roll < 65) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(8, 0);
            end else if (roll < 94) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(3, 0);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(40, 8);
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%h, got 0x%h", name, want, got);
            errors++;
        end
    endtask

    // Compare each column against the oldest expectation
    always @(posedge i_clk) begin : column_checker
        t_column got;
        t_column want;
        if (i_rst_n && m_valid && m_ready) begin
            got.min_mid   = m_data[15:0];
            got.max_mid   = m_data[31:16];
            got.min_left  = m_data[47:32];
            got.max_left  = m_data[63:48];
            got.min_right = m_data[79:64];
            got.max_right = m_data[95:80];
            got.position  = m_data[107:96];
            got.shift     = m_user;
            columns_seen++;
            if (pending_columns.size() == 0) begin
                $error("column result arrived with none expected");
                errors++;
            end else begin
                want = pending_columns.pop_front();
                check_field("min_mid", want.min_mid, got.min_mid);
                check_field("max_mid", want.max_mid, got.max_mid);
                check_field("min_left", want.min_left, got.min_left);
                check_field("max_left", want.max_left, got.max_left);
                check_field("min_right", want.min_right, got.min_right);
                check_field("max_right", want.max_right, got.max_right);
                check_field("column_position", 16'(want.position), 16'(got.position));
                check_field("shift_first", 16'(want.shift), 16'(got.shift));
            end
        end
    end

    // Send one stereo pair and record the column it may close
    task automatic send_pair(input logic signed [15:0] l, input logic signed [15:0] r);
        t_column col;
        int      gap;
        s_valid <= 1'b1;
        s_data  <= {r, l};
        do @(posedge i_clk); while (!s_ready);
        pairs_sent++;
        if (fold_pair(l, r, col)) pending_columns.push_back(col);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every expected column has come
    task automatic wait_columns_done();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_columns.size() != 0) @(posedge i_clk);
    endtask

    // Drain, let the pipeline settle, then write one register
    task automatic write_reg(input logic [smcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        wait_columns_done();
        repeat (PIPE_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            smcd_pkg::CFG_SAMPLES_PER_COLUMN: mdl_spc    = value;
            smcd_pkg::CFG_COLUMN_COUNT:       mdl_ccnt   = value[12:0];
            smcd_pkg::CFG_SCROLL_MODE:        mdl_scroll = value[0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0:       return (($urandom_range(1) != 0) ? 16'sh7FFF : -16'sh8000);
            1:       return (($urandom_range(1) != 0) ? -16'sd1 : 16'sd0);
            default: return 16'($urandom);
        endcase
    endfunction

    // Reset defaults: one pair per column, two columns wrapping
    task automatic test_reset_defaults();
        send_pair(16'sd100, -16'sd100);
        send_pair(-16'sd1, 16'sd0);
        send_pair(16'sd3, 16'sd4);
        send_pair(-16'sd3, -16'sd4);
    endtask

    // Sample extremes and mid rounding toward minus infinity
    task automatic test_sample_extremes();
        send_pair(16'sh7FFF, 16'sh7FFF);
        send_pair(-16'sh8000, -16'sh8000);
        send_pair(16'sh7FFF, -16'sh8000);
        send_pair(-16'sh8000, 16'sh7FFF);
        write_reg(smcd_pkg::CFG_SAMPLES_PER_COLUMN, 16'd4);
        send_pair(16'sh7FFF, -16'sh8000);
        send_pair(-16'sh8000, 16'sh7FFF);
        send_pair(-16'sd1, -16'sd2);
        send_pair(16'sd0, 16'sd0);
    endtask

    // Register corners: zero pairs per column, counts out of range, scroll, unknown index
    task automatic test_register_corners();
        write_reg(smcd_pkg::CFG_SAMPLES_PER_COLUMN, 16'd0);
        write_reg(smcd_pkg::CFG_COLUMN_COUNT, 16'd0);
        send_pair(16'sd5, -16'sd7);
        send_pair(-16'sd9, 16'sd11);
        write_reg(smcd_pkg::CFG_COLUMN_COUNT, 16'd1);
        send_pair(16'sd1, 16'sd2);
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        send_pair(16'sd2, 16'sd1);
        write_reg(smcd_pkg::CFG_SCROLL_MODE, 16'd1);
        write_reg(smcd_pkg::CFG_COLUMN_COUNT, 16'h1FFF);
        send_pair(16'sh1234, -16'sh4321);
        write_reg(smcd_pkg::CFG_COLUMN_COUNT, 16'd4096);
        send_pair(-16'sh1234, 16'sh4321);
        write_reg(smcd_pkg::CFG_SCROLL_MODE, 16'hFFFE);
        send_pair(16'sd7, 16'sd7);
    endtask

    // Shrink the column count below the current position; high data bits dropped
    task automatic test_position_clamp();
        write_reg(smcd_pkg::CFG_COLUMN_COUNT, 16'd20);
        repeat (6) send_pair(rand_sample(), rand_sample());
        write_reg(smcd_pkg::CFG_COLUMN_COUNT, 16'hE003);
        repeat (3) send_pair(rand_sample(), rand_sample());
    endtask

    // Largest pair count, then lower it below the pairs already folded in
    task automatic test_spc_lowered();
        write_reg(smcd_pkg::CFG_SAMPLES_PER_COLUMN, 16'hFFFF);
        repeat (4) send_pair(rand_sample(), rand_sample());
        write_reg(smcd_pkg::CFG_SAMPLES_PER_COLUMN, 16'd2);
        send_pair(16'sd42, -16'sd42);
        send_pair(16'sd1, 16'sd1);
    endtask

    // Random phases with fresh settings, idling and a mid-phase drain
    task automatic test_random_phases();
        int sent;
        int phase_len;
        int roll;
        logic [15:0] spc_val;
        logic [15:0] cnt_val;
        logic signed [15:0] l;
        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            roll = $urandom_range(99);
            if (roll < 70)      spc_val = 16'($urandom_range(8, 1));
            else if (roll < 90) spc_val = 16'($urandom_range(64, 9));
            else if (roll < 95) spc_val = 16'($urandom_range(300, 100));
            else                spc_val = 16'd0;
            roll = $urandom_range(99);
            if (roll < 70)      cnt_val = 16'($urandom_range(16, 2));
            else if (roll < 85) cnt_val = 16'($urandom_range(4096, 17));
            else if (roll < 90) cnt_val = 16'($urandom_range(1, 0));
            else if (roll < 95) cnt_val = 16'($urandom_range(8191, 4097));
            else                cnt_val = 16'd4096;
            write_reg(smcd_pkg::CFG_SAMPLES_PER_COLUMN, spc_val);
            write_reg(smcd_pkg::CFG_COLUMN_COUNT, cnt_val);
            write_reg(smcd_pkg::CFG_SCROLL_MODE, 16'($urandom_range(3) == 0));
            steady = ($urandom_range(5) == 0);
            phase_len = $urandom_range(120, 20);
            for (int k = 0; k < phase_len; k++) begin
                if (k == phase_len / 2 && $urandom_range(2) == 0) wait_columns_done();
                l = rand_sample();
                if ($urandom_range(6) == 0) send_pair(l, l);
                else                        send_pair(l, rand_sample());
            end
            sent += phase_len;
            steady = 1'b0;
        end
    endtask

    initial begin
        mdl_spc    = smcd_pkg::SPC_RESET;
        mdl_ccnt   = smcd_pkg::CCNT_RESET;
        mdl_scroll = 1'b0;
        next_position = '0;
        clear_extremes();

        // Hold reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_sample_extremes();
        test_register_corners();
        test_position_clamp();
        test_spc_lowered();
        test_random_phases();

        wait_columns_done();
        repeat (PIPE_CYCLES * 4) @(posedge i_clk);

        $display("Sent %0d stereo pairs, checked %0d columns in place and scroll modes.",
                 pairs_sent, columns_seen);
        $display("Settings swept pair counts 0..65535 and column counts 0..8191.");
        if (errors == 0 && pending_columns.size() == 0) begin
            $display("stereo_minmax_column_decimator verification clean");
        end else begin
            if (pending_columns.size() != 0)
                $error("%0d expected columns never arrived", pending_columns.size());
            $display("stereo_minmax_column_decimator verification failed");
        end
        $finish;
    end

endmodule
